// ----- rtl/hrsc_pkg.sv -----
// hrsc_pkg: shared types, constants and code tables for the HID report to
// set 1 scancode converter. No dependencies; used by every rtl module.

package hrsc_pkg;

   localparam int KEYS_PER_REPORT = 6;   // 1..6 key slots used per report
   localparam int MAP_ENTRIES     = 256; // usage codes at or above map to 0
   localparam int MAX_KEYS        = 6;   // key slots carried on the port
   localparam int MOD_COUNT       = 8;
   localparam int IDX_W           = 3;
   localparam int KEY_IDX_W       = (KEYS_PER_REPORT > 1) ? $clog2(KEYS_PER_REPORT) : 1;

   localparam int REQ_DATA_W = 88;  // modifiers, 6 keys, now_us
   localparam int RSP_DATA_W = 24;  // scancode, lock_leds, zero fill
   localparam int CFG_W      = 24;

   typedef logic [7:0]  usage_type;
   typedef logic [15:0] code_type;
   typedef logic [2:0]  lock_type;

   // csr register indexes
   localparam logic REG_DELAY    = 1'b0;
   localparam logic REG_INTERVAL = 1'b1;

   // sequencer step codes
   localparam logic [1:0] OP_REP = 2'd0;
   localparam logic [1:0] OP_MOD = 2'd1;
   localparam logic [1:0] OP_BRK = 2'd2;
   localparam logic [1:0] OP_MAK = 2'd3;

   localparam lock_type LOCK_SCROLL = 3'b001;
   localparam lock_type LOCK_NUM    = 3'b010;
   localparam lock_type LOCK_CAPS   = 3'b100;

   localparam code_type CODE_NUM    = 16'h0045;
   localparam code_type CODE_SCROLL = 16'h0046;
   localparam code_type CODE_CAPS   = 16'h003A;
   localparam code_type BREAK_BIT   = 16'h0080;

   localparam logic [23:0] DELAY_RESET    = 24'd300000;
   localparam logic [23:0] INTERVAL_RESET = 24'd100000;

   typedef struct packed {
      logic             load;   // capture the accepted report
      logic             run;    // execute one step
      logic [1:0]       op;
      logic [IDX_W-1:0] idx;
      logic             flush;  // end of report: release last word, save report
   } hrsc_cmd_type;

   typedef struct packed {
      logic out_free;  // output register can take a word this cycle
   } hrsc_sts_type;

   // bit position in the modifier byte, in table order
   function automatic logic [2:0] mod_pos(input logic [IDX_W-1:0] i);
      logic [2:0] p;
      case (i)
         3'd0:    p = 3'd2;
         3'd1:    p = 3'd6;
         3'd2:    p = 3'd0;
         3'd3:    p = 3'd4;
         3'd4:    p = 3'd5;
         3'd5:    p = 3'd1;
         3'd6:    p = 3'd7;
         3'd7:    p = 3'd3;
         default: p = 3'd0;
      endcase
      return p;
   endfunction

   function automatic code_type mod_code(input logic [IDX_W-1:0] i);
      code_type c;
      case (i)
         3'd0:    c = 16'h0038;
         3'd1:    c = 16'hE038;
         3'd2:    c = 16'h001D;
         3'd3:    c = 16'hE01D;
         3'd4:    c = 16'h0036;
         3'd5:    c = 16'h002A;
         3'd6:    c = 16'hE05C;
         3'd7:    c = 16'hE05B;
         default: c = 16'h0000;
      endcase
      return c;
   endfunction

   function automatic code_type usage_rom(input usage_type u);
      code_type c;
      case (u)
         8'd4:  c = 16'h1E;  8'd5:  c = 16'h30;  8'd6:  c = 16'h2E;  8'd7:  c = 16'h20;
         8'd8:  c = 16'h12;  8'd9:  c = 16'h21;  8'd10: c = 16'h22;  8'd11: c = 16'h23;
         8'd12: c = 16'h17;  8'd13: c = 16'h24;  8'd14: c = 16'h25;  8'd15: c = 16'h26;
         8'd16: c = 16'h32;  8'd17: c = 16'h31;  8'd18: c = 16'h18;  8'd19: c = 16'h19;
         8'd20: c = 16'h10;  8'd21: c = 16'h13;  8'd22: c = 16'h1F;  8'd23: c = 16'h14;
         8'd24: c = 16'h16;  8'd25: c = 16'h2F;  8'd26: c = 16'h11;  8'd27: c = 16'h2D;
         8'd28: c = 16'h15;  8'd29: c = 16'h2C;
         8'd30: c = 16'h02;  8'd31: c = 16'h03;  8'd32: c = 16'h04;  8'd33: c = 16'h05;
         8'd34: c = 16'h06;  8'd35: c = 16'h07;  8'd36: c = 16'h08;  8'd37: c = 16'h09;
         8'd38: c = 16'h0A;  8'd39: c = 16'h0B;
         8'd40: c = 16'h1C;  8'd41: c = 16'h01;  8'd42: c = 16'h0E;  8'd43: c = 16'h0F;
         8'd44: c = 16'h39;  8'd45: c = 16'h0C;  8'd46: c = 16'h0D;  8'd47: c = 16'h1A;
         8'd48: c = 16'h1B;  8'd49: c = 16'h2B;  8'd51: c = 16'h27;
         8'd52: c = 16'h28;  8'd53: c = 16'h29;  8'd54: c = 16'h33;  8'd55: c = 16'h34;
         8'd56: c = 16'h35;  8'd57: c = 16'h3A;
         8'd58: c = 16'h3B;  8'd59: c = 16'h3C;  8'd60: c = 16'h3D;  8'd61: c = 16'h3E;
         8'd62: c = 16'h3F;  8'd63: c = 16'h40;  8'd64: c = 16'h41;  8'd65: c = 16'h42;
         8'd66: c = 16'h43;  8'd67: c = 16'h44;  8'd68: c = 16'h57;  8'd69: c = 16'h58;
         8'd70: c = 16'hE037; 8'd71: c = 16'h0046; 8'd72: c = 16'h9DC5; 8'd73: c = 16'hE052;
         8'd74: c = 16'hE047; 8'd75: c = 16'hE049; 8'd76: c = 16'hE053; 8'd77: c = 16'hE04F;
         8'd78: c = 16'hE051; 8'd79: c = 16'hE04D; 8'd80: c = 16'hE04B; 8'd81: c = 16'hE050;
         8'd82: c = 16'hE048;
         8'd83: c = 16'h45;   8'd84: c = 16'hE035; 8'd85: c = 16'h37;   8'd86: c = 16'h4A;
         8'd87: c = 16'h4E;   8'd88: c = 16'hE01C;
         8'd89: c = 16'h4F;  8'd90: c = 16'h50;  8'd91: c = 16'h51;  8'd92: c = 16'h4B;
         8'd93: c = 16'h4C;  8'd94: c = 16'h4D;  8'd95: c = 16'h47;  8'd96: c = 16'h48;
         8'd97: c = 16'h49;  8'd98: c = 16'h52;  8'd99: c = 16'h53;
         8'd101: c = 16'hE05D;
         default: c = 16'h0000;
      endcase
      if ({1'b0, u} >= 9'(MAP_ENTRIES)) c = 16'h0000;
      return c;
   endfunction

endpackage

// ----- rtl/hrsc_ctrl.sv -----
// hrsc_ctrl: sequencer for one report: repeat check, modifier table walk,
// key break scan, key make scan, finish. Depends on hrsc_pkg.

module hrsc_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  hrsc_pkg::hrsc_sts_type sts,
   output hrsc_pkg::hrsc_cmd_type cmd
);
   import hrsc_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_REP  = 3'd1;
   localparam logic [2:0] ST_MOD  = 3'd2;
   localparam logic [2:0] ST_BRK  = 3'd3;
   localparam logic [2:0] ST_MAK  = 3'd4;
   localparam logic [2:0] ST_FIN  = 3'd5;

   logic [2:0]       state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             last_key;

   assign last_key   = (idx_ff == IDX_W'(KEYS_PER_REPORT - 1));
   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      cmd       = '0;
      cmd.idx   = idx_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_REP;
            end
         end
         ST_REP: begin
            cmd.op = OP_REP;
            if (sts.out_free) begin
               cmd.run  = 1'b1;
               idx_in   = '0;
               state_in = ST_MOD;
            end
         end
         ST_MOD: begin
            cmd.op = OP_MOD;
            if (sts.out_free) begin
               cmd.run = 1'b1;
               if (idx_ff == IDX_W'(MOD_COUNT - 1)) begin
                  idx_in   = '0;
                  state_in = ST_BRK;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         ST_BRK: begin
            cmd.op = OP_BRK;
            if (sts.out_free) begin
               cmd.run = 1'b1;
               if (last_key) begin
                  idx_in   = '0;
                  state_in = ST_MAK;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         ST_MAK: begin
            cmd.op = OP_MAK;
            if (sts.out_free) begin
               cmd.run = 1'b1;
               if (last_key) begin
                  idx_in   = '0;
                  state_in = ST_FIN;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         ST_FIN: begin
            if (sts.out_free) begin
               cmd.flush = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   a_run_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.run |-> sts.out_free) else $error("step issued with output full");
   a_load_starts: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (state_ff == ST_REP)) else $error("load did not start sequence");
   a_no_run_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (!cmd.run && !cmd.flush)) else $error("step while idle");

endmodule

// ----- rtl/hrsc_dp.sv -----
// hrsc_dp: report registers, repeat state, lock bits, one-word hold stage
// and output register. Driven by hrsc_ctrl commands. Depends on hrsc_pkg.

module hrsc_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  hrsc_pkg::hrsc_cmd_type        cmd,
   output hrsc_pkg::hrsc_sts_type        sts,
   input  logic [hrsc_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                          csr_we,
   input  logic                          csr_addr,
   input  logic [hrsc_pkg::CFG_W-1:0]    csr_wdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [hrsc_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                          rsp_tlast
);
   import hrsc_pkg::*;

   logic [CFG_W-1:0] delay_ff, delay_in, interval_ff, interval_in;
   usage_type        mods_ff, mods_in, prev_mods_ff, prev_mods_in;
   usage_type        keys_ff [KEYS_PER_REPORT];
   usage_type        keys_in [KEYS_PER_REPORT];
   usage_type        prev_keys_ff [KEYS_PER_REPORT];
   usage_type        prev_keys_in [KEYS_PER_REPORT];
   logic [31:0]      now_ff, now_in, mark_ff, mark_in;
   code_type         rep_code_ff, rep_code_in;
   logic             armed_ff, armed_in;
   lock_type         lock_ff, lock_in;
   logic             pend_valid_ff, pend_valid_in;
   code_type         pend_code_ff, pend_code_in;
   lock_type         pend_lock_ff, pend_lock_in;
   logic             out_valid_ff, out_valid_in;
   code_type         out_code_ff, out_code_in;
   lock_type         out_lock_ff, out_lock_in;
   logic             out_last_ff, out_last_in;

   logic [KEY_IDX_W-1:0] kidx;
   usage_type        u_brk, u_mak, rom_addr;
   logic             hit_brk, hit_mak;
   code_type         rom_code;
   logic [2:0]       mpos;
   logic             act_rep, act_make, act_brk;
   code_type         act_code;
   logic [31:0]      elapsed;
   logic             do_emit;
   code_type         emit_code;
   lock_type         lock_mask;

   assign sts.out_free = !out_valid_ff || rsp_tready;
   assign kidx         = cmd.idx[KEY_IDX_W-1:0];
   assign u_brk        = prev_keys_ff[kidx];
   assign u_mak        = keys_ff[kidx];
   assign rom_addr     = (cmd.op == OP_BRK) ? u_brk : u_mak;
   assign rom_code     = usage_rom(rom_addr);
   assign mpos         = mod_pos(cmd.idx);
   assign elapsed      = now_ff - mark_ff;

   always_comb begin
      hit_brk = 1'b0;
      hit_mak = 1'b0;
      for (int i = 0; i < KEYS_PER_REPORT; i++) begin
         if (keys_ff[i] == u_brk) hit_brk = 1'b1;
         if (prev_keys_ff[i] == u_mak) hit_mak = 1'b1;
      end
   end

   // decode what this step does
   always_comb begin
      act_rep  = 1'b0;
      act_make = 1'b0;
      act_brk  = 1'b0;
      act_code = rom_code;
      if (cmd.run) begin
         case (cmd.op)
            OP_REP: act_rep = 1'b1;
            OP_MOD: begin
               act_code = mod_code(cmd.idx);
               if (prev_mods_ff[mpos] && !mods_ff[mpos]) act_brk = 1'b1;
               else if (mods_ff[mpos] && !prev_mods_ff[mpos]) act_make = 1'b1;
            end
            OP_BRK: act_brk = (u_brk != '0) && !hit_brk;
            OP_MAK: begin
               if ((u_mak != '0) && !hit_mak) begin
                  // unmapped make falls back to the repeat check
                  if (rom_code == '0) act_rep = 1'b1;
                  else act_make = 1'b1;
               end
            end
            default: act_rep = 1'b0;
         endcase
      end
   end

   always_comb begin
      case (act_code)
         CODE_NUM:    lock_mask = LOCK_NUM;
         CODE_SCROLL: lock_mask = LOCK_SCROLL;
         CODE_CAPS:   lock_mask = LOCK_CAPS;
         default:     lock_mask = '0;
      endcase
   end

   always_comb begin
      delay_in      = delay_ff;
      interval_in   = interval_ff;
      mods_in       = mods_ff;
      keys_in       = keys_ff;
      now_in        = now_ff;
      prev_mods_in  = prev_mods_ff;
      prev_keys_in  = prev_keys_ff;
      mark_in       = mark_ff;
      rep_code_in   = rep_code_ff;
      armed_in      = armed_ff;
      lock_in       = lock_ff;
      pend_valid_in = pend_valid_ff;
      pend_code_in  = pend_code_ff;
      pend_lock_in  = pend_lock_ff;
      out_valid_in  = out_valid_ff && !rsp_tready;
      out_code_in   = out_code_ff;
      out_lock_in   = out_lock_ff;
      out_last_in   = out_last_ff;
      do_emit       = 1'b0;
      emit_code     = act_code;

      if (csr_we) begin
         if (csr_addr == REG_DELAY) delay_in = csr_wdata;
         else interval_in = csr_wdata;
      end

      if (cmd.load) begin
         mods_in = req_tdata[7:0];
         for (int i = 0; i < KEYS_PER_REPORT; i++) keys_in[i] = req_tdata[8*i+8 +: 8];
         now_in = req_tdata[8*MAX_KEYS+8 +: 32];
      end

      if (act_rep && (rep_code_ff != '0)) begin
         if (armed_ff) begin
            if (elapsed >= {8'd0, interval_ff}) begin
               mark_in   = now_ff;
               do_emit   = 1'b1;
               emit_code = rep_code_ff;
            end
         end else if (elapsed >= {8'd0, delay_ff}) begin
            mark_in  = now_ff;
            armed_in = 1'b1;
         end
      end
      if (act_make) begin
         rep_code_in = act_code;
         mark_in     = now_ff;
         armed_in    = 1'b0;
         lock_in     = lock_ff ^ lock_mask;
         do_emit     = 1'b1;
      end
      if (act_brk) begin
         rep_code_in = '0;
         do_emit     = 1'b1;
         emit_code   = act_code | BREAK_BIT;
      end

      // hold each word until the next one shows whether it ends the run
      if (do_emit) begin
         if (pend_valid_ff) begin
            out_valid_in = 1'b1;
            out_code_in  = pend_code_ff;
            out_lock_in  = pend_lock_ff;
            out_last_in  = 1'b0;
         end
         pend_valid_in = 1'b1;
         pend_code_in  = emit_code;
         pend_lock_in  = lock_in;
      end

      if (cmd.flush) begin
         if (pend_valid_ff) begin
            out_valid_in = 1'b1;
            out_code_in  = pend_code_ff;
            out_lock_in  = pend_lock_ff;
            out_last_in  = 1'b1;
         end
         pend_valid_in = 1'b0;
         prev_mods_in  = mods_ff;
         prev_keys_in  = keys_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_in_reset: begin
            delay_ff      <= DELAY_RESET;
            interval_ff   <= INTERVAL_RESET;
         end
         prev_mods_ff  <= '0;
         for (int i = 0; i < KEYS_PER_REPORT; i++) prev_keys_ff[i] <= '0;
         mark_ff       <= '0;
         rep_code_ff   <= '0;
         armed_ff      <= 1'b0;
         lock_ff       <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         delay_ff      <= delay_in;
         interval_ff   <= interval_in;
         prev_mods_ff  <= prev_mods_in;
         prev_keys_ff  <= prev_keys_in;
         mark_ff       <= mark_in;
         rep_code_ff   <= rep_code_in;
         armed_ff      <= armed_in;
         lock_ff       <= lock_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mods_ff      <= mods_in;
      keys_ff      <= keys_in;
      now_ff       <= now_in;
      pend_code_ff <= pend_code_in;
      pend_lock_ff <= pend_lock_in;
      out_code_ff  <= out_code_in;
      out_lock_ff  <= out_lock_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - 19){1'b0}}, out_lock_ff, out_code_ff};
   assign rsp_tlast  = out_last_ff;

   a_flush_empties: assert property (@(posedge clock) disable iff (reset)
      cmd.flush |=> !pend_valid_ff) else $error("hold stage not empty after flush");
   a_lock_on_step: assert property (@(posedge clock) disable iff (reset)
      !cmd.run |=> $stable(lock_ff)) else $error("lock bits moved outside a step");
   a_last_has_flush: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_last_ff && !$past(out_valid_ff && out_last_ff))
      |-> $past(cmd.flush)) else $error("last word without end of report");

endmodule

// ----- rtl/hid_report_to_scancode_converter.sv -----
// hid_report_to_scancode_converter: top level joining sequencer and datapath.
// Depends on hrsc_pkg, hrsc_ctrl and hrsc_dp.

// Takes one keyboard report per req_ word and returns its set 1 scancodes as
// a run of rsp_ words, rsp_tlast on the final one; a report that causes no
// code returns nothing. One report at a time: a report occupies the block from
// accept to the next accept, going through the repeat check, one step per
// modifier table entry, one per key slot for breaks and again for makes, and
// finish; each step also waits while a refused rsp_ word holds the output.
// The user must write the delay and interval registers on the csr_ port only
// while no report is in work; the block itself does not enforce this.

module hid_report_to_scancode_converter (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // modifiers, key_0 .. key_5, now_us (low to high)
   input  logic [hrsc_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // scancode, lock_leds, zero fill (low to high)
   output logic [hrsc_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                            rsp_tlast,
   input  logic                            csr_we,
   input  logic                            csr_addr,
   input  logic [hrsc_pkg::CFG_W-1:0]      csr_wdata
);
   import hrsc_pkg::*;

   hrsc_cmd_type cmd;
   hrsc_sts_type sts;

   hrsc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   hrsc_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ----- bench/hrsc_scan_checker.sv -----
// hrsc_scan_checker: watches the report, scancode and csr ports of the converter,
// predicts the scancode words of every accepted report and compares them in order.
// Depends on hrsc_pkg for widths, register indexes, lock and code constants.

module hrsc_scan_checker
   import hrsc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  rsp_tlast,
   input  logic                  csr_we,
   input  logic                  csr_addr,
   input  logic [CFG_W-1:0]      csr_wdata,
   output int                    fail_count,
   output int                    pending_words
);

   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_RUN = 21;

   typedef struct packed {
      code_type code;
      logic     last;
      lock_type leds;
   } scan_word_type;

   typedef usage_type key_list_type [MAX_KEYS];

   // set 1 codes by HID usage; usages past the table give 0
   code_type usage_scan [0:103] = '{
      16'h0000, 16'h0000, 16'h0000, 16'h0000,
      16'h001E, 16'h0030, 16'h002E, 16'h0020, 16'h0012, 16'h0021, 16'h0022, 16'h0023,
      16'h0017, 16'h0024, 16'h0025, 16'h0026,
      16'h0032, 16'h0031, 16'h0018, 16'h0019, 16'h0010, 16'h0013, 16'h001F, 16'h0014,
      16'h0016, 16'h002F, 16'h0011, 16'h002D,
      16'h0015, 16'h002C,
      16'h0002, 16'h0003, 16'h0004, 16'h0005, 16'h0006, 16'h0007, 16'h0008, 16'h0009,
      16'h000A, 16'h000B,
      16'h001C, 16'h0001, 16'h000E, 16'h000F, 16'h0039, 16'h000C, 16'h000D, 16'h001A,
      16'h001B, 16'h002B, 16'h0000, 16'h0027,
      16'h0028, 16'h0029, 16'h0033, 16'h0034, 16'h0035, 16'h003A,
      16'h003B, 16'h003C, 16'h003D, 16'h003E, 16'h003F, 16'h0040, 16'h0041, 16'h0042,
      16'h0043, 16'h0044, 16'h0057, 16'h0058,
      16'hE037, 16'h0046, 16'h9DC5, 16'hE052, 16'hE047, 16'hE049, 16'hE053, 16'hE04F,
      16'hE051, 16'hE04D, 16'hE04B, 16'hE050, 16'hE048,
      16'h0045, 16'hE035, 16'h0037, 16'h004A, 16'h004E, 16'hE01C,
      16'h004F, 16'h0050, 16'h0051, 16'h004B, 16'h004C, 16'h004D, 16'h0047, 16'h0048,
      16'h0049, 16'h0052, 16'h0053,
      16'h0000, 16'hE05D, 16'h0000, 16'h0000
   };

   // modifier table order: bit position in the byte and its code
   int       mod_bit_pos [0:7] = '{2, 6, 0, 4, 5, 1, 7, 3};
   code_type mod_scan    [0:7] = '{16'h0038, 16'hE038, 16'h001D, 16'hE01D,
                                   16'h0036, 16'h002A, 16'hE05C, 16'hE05B};

   logic [23:0]   delay_cfg;
   logic [23:0]   interval_cfg;
   logic [7:0]    held_mods;
   key_list_type  held_keys;
   code_type      rep_code;
   logic [31:0]   rep_mark;
   logic          rep_armed;
   lock_type      locks;
   int            fails;

   scan_word_type run_words [$];
   scan_word_type scan_expected [$];

   initial begin
      fail_count    = 0;
      pending_words = 0;
      fails         = 0;
   end

   function automatic code_type scan_of(input usage_type u);
      if (int'(u) >= MAP_ENTRIES || int'(u) > 103) return '0;
      return usage_scan[u];
   endfunction

   function automatic void put_code(input code_type c);
      scan_word_type w;
      if (run_words.size() >= MAX_RUN) return;
      w.code = c;
      w.last = 1'b0;
      w.leds = locks;
      run_words.push_back(w);
   endfunction

   function automatic void check_repeat(input logic [31:0] stamp);
      logic [31:0] elapsed;
      if (rep_code == '0) return;
      elapsed = stamp - rep_mark;
      if (rep_armed) begin
         if (elapsed >= {8'd0, interval_cfg}) begin
            rep_mark = stamp;
            put_code(rep_code);
         end
      end else if (elapsed >= {8'd0, delay_cfg}) begin
         rep_mark  = stamp;
         rep_armed = 1'b1;
      end
   endfunction

   function automatic void do_make(input code_type c, input logic [31:0] stamp);
      // unmapped key: only another repeat check
      if (c == '0) begin
         check_repeat(stamp);
         return;
      end
      rep_code  = c;
      rep_mark  = stamp;
      rep_armed = 1'b0;
      if (c == CODE_NUM) locks ^= LOCK_NUM;
      else if (c == CODE_SCROLL) locks ^= LOCK_SCROLL;
      else if (c == CODE_CAPS) locks ^= LOCK_CAPS;
      put_code(c);
   endfunction

   function automatic void do_break(input code_type c);
      rep_code = '0;
      put_code(c | BREAK_BIT);
   endfunction

   function automatic logic key_present(input key_list_type list, input usage_type u);
      for (int i = 0; i < KEYS_PER_REPORT; i++)
         if (list[i] == u) return 1'b1;
      return 1'b0;
   endfunction

   function automatic void predict_scancodes(input logic [REQ_DATA_W-1:0] word);
      logic [7:0]   mods;
      logic [7:0]   pressed;
      logic [7:0]   released;
      logic [31:0]  stamp;
      key_list_type keys;
      mods  = word[7:0];
      stamp = word[56 +: 32];
      for (int i = 0; i < MAX_KEYS; i++)
         keys[i] = (i < KEYS_PER_REPORT) ? word[8 + 8*i +: 8] : '0;
      run_words.delete();

      check_repeat(stamp);
      pressed  = mods & ~held_mods;
      released = held_mods & ~mods;
      for (int i = 0; i < MOD_COUNT; i++) begin
         if (released[mod_bit_pos[i]]) do_break(mod_scan[i]);
         if (pressed[mod_bit_pos[i]]) do_make(mod_scan[i], stamp);
      end
      for (int i = 0; i < KEYS_PER_REPORT; i++)
         if (held_keys[i] != '0 && !key_present(keys, held_keys[i]))
            do_break(scan_of(held_keys[i]));
      for (int i = 0; i < KEYS_PER_REPORT; i++)
         if (keys[i] != '0 && !key_present(held_keys, keys[i]))
            do_make(scan_of(keys[i]), stamp);

      held_mods = mods;
      held_keys = keys;
      if (run_words.size() > 0) run_words[run_words.size() - 1].last = 1'b1;
      foreach (run_words[j]) scan_expected.push_back(run_words[j]);
   endfunction

   always @(posedge clock) begin : monitor
      scan_word_type want;
      if (reset) begin
         delay_cfg    = DELAY_RESET;
         interval_cfg = INTERVAL_RESET;
         held_mods    = '0;
         foreach (held_keys[i]) held_keys[i] = '0;
         rep_code     = '0;
         rep_mark     = '0;
         rep_armed    = 1'b0;
         locks        = '0;
         scan_expected.delete();
      end else begin
         if (csr_we) begin
            if (csr_addr == REG_DELAY) delay_cfg = csr_wdata;
            else if (csr_addr == REG_INTERVAL) interval_cfg = csr_wdata;
         end
         if (req_tvalid && req_tready) predict_scancodes(req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            if (scan_expected.size() == 0) begin
               $error("unexpected word: scancode %h last %b", rsp_tdata[15:0], rsp_tlast);
               fails++;
            end else begin
               want = scan_expected.pop_front();
               if (rsp_tdata[15:0] !== want.code) begin
                  $error("scancode: expected %h, got %h", want.code, rsp_tdata[15:0]);
                  fails++;
               end
               if (rsp_tlast !== want.last) begin
                  $error("last_of_run: expected %b, got %b", want.last, rsp_tlast);
                  fails++;
               end
               if (rsp_tdata[18:16] !== want.leds) begin
                  $error("lock_leds: expected %h, got %h", want.leds, rsp_tdata[18:16]);
                  fails++;
               end
            end
         end
      end
      fail_count    <= fails;
      pending_words <= scan_expected.size();
   end

endmodule

// ----- bench/tb.sv -----
// tb: drives keyboard reports and csr settings into the converter, with bursty
// input and a stalling scancode sink. Depends on hrsc_pkg and hrsc_scan_checker.

module tb;

   timeunit 1ns;
   timeprecision 1ps;

   import hrsc_pkg::*;

   localparam int SETTLE     = 2 * KEYS_PER_REPORT + 30;
   localparam int IDLE_LIMIT = 4000;
   localparam int SQUEEZE    = 400;
   localparam int PHASE_LEN  = 60;

   localparam usage_type USAGE_CAPS   = 8'd57;
   localparam usage_type USAGE_SCROLL = 8'd71;
   localparam usage_type USAGE_NUM    = 8'd83;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_we = 1'b0;
   logic                  csr_addr = REG_DELAY;
   logic [CFG_W-1:0]      csr_wdata = '0;

   int fail_count;
   int pending_words;
   int idle_cycles = 0;
   int burst_left = 1;

   logic squeeze_go = 1'b0;
   logic squeeze_done = 1'b0;

   logic [7:0]  cur_mods = '0;
   usage_type   cur_keys [MAX_KEYS];
   logic [31:0] cur_now = '0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   hid_report_to_scancode_converter DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   hrsc_scan_checker scan_check (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast),
      .csr_we        (csr_we),
      .csr_addr      (csr_addr),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending_words (pending_words)
   );

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // scancode sink: its own stall pattern, plus one long hold-off on request
   initial begin : receiver
      int span;
      int mode;
      forever begin
         if (squeeze_go && !squeeze_done) begin
            rsp_tready <= 1'b0;
            repeat (SQUEEZE) @(posedge clock);
            squeeze_done = 1'b1;
         end else begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(1, 40);
            repeat (span) begin
               case (mode)
                  0:       rsp_tready <= 1'b1;
                  1:       rsp_tready <= ($urandom_range(0, 1) == 1);
                  2:       rsp_tready <= ($urandom_range(0, 3) == 0);
                  default: rsp_tready <= 1'b0;
               endcase
               @(posedge clock);
            end
         end
      end
   end

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_words != 0) @(posedge clock);
   endtask

   // offers the current report, then applies the burst/gap pacing
   task automatic send_report();
      logic [REQ_DATA_W-1:0] word;
      int gap;
      word = '0;
      word[7:0] = cur_mods;
      for (int i = 0; i < MAX_KEYS; i++) word[8 + 8*i +: 8] = cur_keys[i];
      word[56 +: 32] = cur_now;
      req_tdata  <= word;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      burst_left--;
      if (burst_left <= 0 && !(squeeze_go && !squeeze_done)) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 4);
         if ($urandom_range(0, 5) == 0)
            wait_drained();
         else if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // block is idle here: all words back and the last report fully retired
   task automatic set_repeat_timing(input logic [23:0] delay_us, input logic [23:0] interval_us);
      wait_drained();
      repeat (SETTLE) @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= REG_DELAY;
      csr_wdata <= delay_us;
      @(posedge clock);
      csr_addr  <= REG_INTERVAL;
      csr_wdata <= interval_us;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic play_report(input logic [7:0] mods, input usage_type k0, input usage_type k1,
                              input usage_type k2, input usage_type k3, input usage_type k4,
                              input usage_type k5, input logic [31:0] stamp);
      cur_mods    = mods;
      cur_keys[0] = k0;
      cur_keys[1] = k1;
      cur_keys[2] = k2;
      cur_keys[3] = k3;
      cur_keys[4] = k4;
      cur_keys[5] = k5;
      cur_now     = stamp;
      send_report();
   endtask

   function automatic usage_type pick_usage();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 7) return usage_type'($urandom_range(4, 101));
      if (sel == 7) begin
         case ($urandom_range(0, 2))
            0:       return USAGE_CAPS;
            1:       return USAGE_SCROLL;
            default: return USAGE_NUM;
         endcase
      end
      if (sel == 8) return usage_type'($urandom_range(0, 255));
      return cur_keys[$urandom_range(0, MAX_KEYS - 1)];  // duplicate in report
   endfunction

   // mostly typing-like changes to the last report; some pure noise
   function automatic void roll_report(input int step_max);
      int slot;
      slot = $urandom_range(0, MAX_KEYS - 1);
      if ($urandom_range(0, 7) == 0) begin
         cur_mods = 8'($urandom);
         foreach (cur_keys[i]) cur_keys[i] = usage_type'($urandom);
      end else begin
         case ($urandom_range(0, 9))
            0, 1, 2: ;                                  // hold, lets repeat run
            3, 4:    cur_keys[slot] = pick_usage();
            5, 6:    cur_keys[slot] = '0;
            7:       cur_mods[$urandom_range(0, 7)] ^= 1'b1;
            8:       cur_keys[slot] = usage_type'($urandom_range(0, 255));
            default: begin
               cur_mods = '0;
               foreach (cur_keys[i]) cur_keys[i] = '0;
            end
         endcase
      end
      if ($urandom_range(0, 15) == 0)
         cur_now = $urandom;
      else
         cur_now += $urandom_range(0, step_max);
   endfunction

   task automatic random_phase(input logic [23:0] delay_us, input logic [23:0] interval_us,
                               input int step_max, input logic squeeze);
      set_repeat_timing(delay_us, interval_us);
      if (squeeze) squeeze_go <= 1'b1;
      repeat (PHASE_LEN) begin
         roll_report(step_max);
         send_report();
      end
   endtask

   initial begin
      foreach (cur_keys[i]) cur_keys[i] = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset timing: modifiers, six keys, arm then repeat, locks, odd usages
      play_report(8'hFF, 0, 0, 0, 0, 0, 0, 32'd1000);
      play_report(8'h00, 4, 5, 6, 7, 8, 9, 32'd1010);
      play_report(8'h00, 4, 5, 6, 7, 8, 9, 32'd301010);
      play_report(8'h00, 4, 5, 6, 7, 8, 9, 32'd401010);
      play_report(8'h00, USAGE_CAPS, USAGE_SCROLL, USAGE_NUM, 0, 0, 0, 32'd401020);
      play_report(8'h5A, 70, 72, 88, 101, 255, 50, 32'd401030);
      play_report(8'hA5, 0, 0, 0, 0, 0, 0, 32'd401040);
      play_report(8'h00, 20, 20, 20, 0, 0, 0, 32'd401050);
      play_report(8'h00, 20, 0, 0, 0, 0, 0, 32'd401060);
      play_report(8'h00, USAGE_CAPS, USAGE_CAPS, 0, 0, 0, 0, 32'd401070);
      // time wrap between make, arm and repeat
      play_report(8'h00, 4, 0, 0, 0, 0, 0, 32'hFFFF_FF00);
      play_report(8'h00, 4, 0, 0, 0, 0, 0, 32'h0004_9400);
      play_report(8'h00, 4, 0, 0, 0, 0, 0, 32'h0006_0000);
      play_report(8'h00, 4, 0, 0, 0, 0, 0, 32'hFFFF_FFFF);

      // zero delay and interval: longest possible run, then repeats on unmapped makes
      set_repeat_timing(24'd0, 24'd0);
      play_report(8'hFF, 4, 5, 6, 7, 8, 9, 32'd100);
      play_report(8'hFF, 4, 5, 6, 7, 8, 9, 32'd100);
      play_report(8'h00, 10, 11, 12, 13, 14, 15, 32'd100);
      play_report(8'h00, 10, 11, 12, 13, 14, 15, 32'd100);
      play_report(8'h00, 10, 1, 2, 3, 50, 100, 32'd100);
      play_report(8'h00, 0, 0, 0, 0, 0, 0, 32'd100);

      random_phase(DELAY_RESET, INTERVAL_RESET, 200000, 1'b1);
      random_phase(24'd0, 24'd0, 3, 1'b0);
      random_phase(24'hFF_FFFF, 24'hFF_FFFF, 8000000, 1'b0);
      random_phase(24'($urandom_range(0, 5000)), 24'($urandom_range(0, 5000)), 6000, 1'b0);
      random_phase(24'hFF_FFFF, 24'd0, 4000000, 1'b0);

      wait_drained();
      repeat (SETTLE) @(posedge clock);
      if (fail_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/hrsc_pkg.sv
rtl/hrsc_ctrl.sv
rtl/hrsc_dp.sv
rtl/hid_report_to_scancode_converter.sv
bench/hrsc_scan_checker.sv
bench/tb.sv
